FILE: design/r6dft_pkg.sv
package r6dft_pkg;

    typedef struct packed {
        logic valid;
        logic last;
        logic inv;
    } ctl_t;

    // Square root rounded to nearest, evaluated at elaboration for coefficients.
    function automatic longint unsigned round_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned bv;
        longint unsigned rem;
        r   = 0;
        bv  = 64'h4000_0000_0000_0000;
        rem = n;
        for (int i = 0; i < 32; i++)
        begin
            if (bv > n)
            begin
                bv = bv >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bv != 0)
            begin
                if (rem >= r + bv)
                begin
                    rem = rem - (r + bv);
                    r   = (r >> 1) + bv;
                end
                else
                begin
                    r = r >> 1;
                end
                bv = bv >> 2;
            end
        end
        if (rem > r)
        begin
            r = r + 1;
        end
        return r;
    endfunction

endpackage

FILE: design/r6dft_pre.sv
module r6dft_pre #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  r6dft_pkg::ctl_t     in_ctl,
    input  logic signed [W-1:0] x0,
    input  logic signed [W-1:0] x1,
    input  logic signed [W-1:0] x2,
    input  logic signed [W-1:0] x3,
    input  logic signed [W-1:0] x4,
    input  logic signed [W-1:0] x5,
    output r6dft_pkg::ctl_t     out_ctl,
    output logic signed [W+1:0] ma,
    output logic signed [W+1:0] mb,
    output logic signed [W+2:0] u0,
    output logic signed [W+2:0] u1,
    output logic signed [W+2:0] u2,
    output logic signed [W+2:0] u3
);

    localparam int AW = W + 1;
    localparam int MW = W + 2;
    localparam int UW = W + 3;

    r6dft_pkg::ctl_t ctl1_reg;
    r6dft_pkg::ctl_t ctl2_reg;

    logic signed [AW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [AW-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic signed [MW-1:0] ma_reg, mb_reg, ma_next, mb_next;
    logic signed [UW-1:0] u0_reg, u1_reg, u2_reg, u3_reg;
    logic signed [UW-1:0] u0_next, u1_next, u2_next, u3_next;

    // First level: pairwise sums and differences, paired by mode.
    always_comb
    begin
        if (in_ctl.inv)
        begin
            p0_next = AW'(x0) + AW'(x5);
            p1_next = AW'(x0) - AW'(x5);
            p2_next = AW'(x1) + AW'(x3);
            p3_next = AW'(x1) - AW'(x3);
        end
        else
        begin
            p0_next = AW'(x0) + AW'(x3);
            p1_next = AW'(x0) - AW'(x3);
            p2_next = AW'(x1) + AW'(x2);
            p3_next = AW'(x1) - AW'(x2);
        end
        p4_next = in_ctl.inv ? AW'(x2) + AW'(x4) : AW'(x5) + AW'(x4);
        p5_next = in_ctl.inv ? AW'(x2) - AW'(x4) : AW'(x5) - AW'(x4);
    end

    // Second level: multiplier operands and the terms for the final sums.
    always_comb
    begin
        if (ctl1_reg.inv)
        begin
            ma_next = MW'(p4_reg);
            mb_next = MW'(p5_reg);
            u0_next = UW'(p1_reg) + UW'(p3_reg);
            u1_next = UW'(p0_reg) - UW'(p2_reg);
            u2_next = UW'(p0_reg) + (UW'(p2_reg) <<< 1);
            u3_next = UW'(p1_reg) - (UW'(p3_reg) <<< 1);
        end
        else
        begin
            ma_next = MW'(p4_reg) - MW'(p2_reg);
            mb_next = MW'(p5_reg) - MW'(p3_reg);
            u0_next = UW'(p0_reg);
            u1_next = UW'(p1_reg);
            u2_next = UW'(p2_reg) + UW'(p4_reg);
            u3_next = UW'(p3_reg) + UW'(p5_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            ma_reg <= ma_next;
            mb_reg <= mb_next;
            u0_reg <= u0_next;
            u1_reg <= u1_next;
            u2_reg <= u2_next;
            u3_reg <= u3_next;
        end
    end

    assign out_ctl = ctl2_reg;
    assign ma      = ma_reg;
    assign mb      = mb_reg;
    assign u0      = u0_reg;
    assign u1      = u1_reg;
    assign u2      = u2_reg;
    assign u3      = u3_reg;

endmodule

FILE: design/r6dft_mul.sv
module r6dft_mul #(
    parameter int W = 16,
    parameter int F = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  r6dft_pkg::ctl_t       in_ctl,
    input  logic signed [W+1:0]   ma,
    input  logic signed [W+1:0]   mb,
    input  logic signed [W+2:0]   u0_in,
    input  logic signed [W+2:0]   u1_in,
    input  logic signed [W+2:0]   u2_in,
    input  logic signed [W+2:0]   u3_in,
    output r6dft_pkg::ctl_t       out_ctl,
    output logic signed [W+F+3:0] pa,
    output logic signed [W+F+3:0] pb,
    output logic signed [W+2:0]   u0,
    output logic signed [W+2:0]   u1,
    output logic signed [W+2:0]   u2,
    output logic signed [W+2:0]   u3
);

    localparam int PW = W + F + 4;
    localparam int CW = F + 2;
    localparam longint unsigned CHALF = r6dft_pkg::round_sqrt(64'd3 << (2 * F - 2));
    localparam longint unsigned CFULL = r6dft_pkg::round_sqrt(64'd3 << (2 * F));
    localparam logic signed [CW-1:0] COEF_HALF = CW'(CHALF);
    localparam logic signed [CW-1:0] COEF_FULL = CW'(CFULL);

    r6dft_pkg::ctl_t ctl_reg;

    logic signed [CW-1:0]  coef;
    logic signed [PW-1:0]  pa_reg, pb_reg, pa_next, pb_next;
    logic signed [W+2:0]   u0_reg, u1_reg, u2_reg, u3_reg;

    // sqrt(3)/2 scales the forward imaginary parts, sqrt(3) the inverse ones.
    assign coef    = in_ctl.inv ? COEF_FULL : COEF_HALF;
    assign pa_next = PW'(ma) * PW'(coef);
    assign pb_next = PW'(mb) * PW'(coef);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            u0_reg <= u0_in;
            u1_reg <= u1_in;
            u2_reg <= u2_in;
            u3_reg <= u3_in;
        end
    end

    assign out_ctl = ctl_reg;
    assign pa      = pa_reg;
    assign pb      = pb_reg;
    assign u0      = u0_reg;
    assign u1      = u1_reg;
    assign u2      = u2_reg;
    assign u3      = u3_reg;

endmodule

FILE: design/r6dft_post.sv
module r6dft_post #(
    parameter int W = 16,
    parameter int F = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  r6dft_pkg::ctl_t       in_ctl,
    input  logic signed [W+F+3:0] pa,
    input  logic signed [W+F+3:0] pb,
    input  logic signed [W+2:0]   u0,
    input  logic signed [W+2:0]   u1,
    input  logic signed [W+2:0]   u2,
    input  logic signed [W+2:0]   u3,
    output r6dft_pkg::ctl_t       out_ctl,
    output logic signed [W+3:0]   y0,
    output logic signed [W+3:0]   y1,
    output logic signed [W+3:0]   y2,
    output logic signed [W+3:0]   y3,
    output logic signed [W+3:0]   y4,
    output logic signed [W+3:0]   y5
);

    localparam int PW = W + F + 4;
    localparam int OW = W + 4;
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (F - 1);

    r6dft_pkg::ctl_t ctl_reg;

    logic signed [PW-1:0] ra_full, rb_full;
    logic signed [OW-1:0] ra, rb;
    logic signed [OW-1:0] e0, e1, e2, e3;
    logic signed [OW-1:0] y0_reg, y1_reg, y2_reg, y3_reg, y4_reg, y5_reg;
    logic signed [OW-1:0] y0_next, y1_next, y2_next, y3_next, y4_next, y5_next;

    // Round to nearest, ties toward plus infinity.
    assign ra_full = (pa + HALF_LSB) >>> F;
    assign rb_full = (pb + HALF_LSB) >>> F;
    assign ra      = ra_full[OW-1:0];
    assign rb      = rb_full[OW-1:0];

    assign e0 = OW'(u0);
    assign e1 = OW'(u1);
    assign e2 = OW'(u2);
    assign e3 = OW'(u3);

    always_comb
    begin
        if (in_ctl.inv)
        begin
            y0_next = e2;
            y1_next = e0 - ra;
            y2_next = e1 - rb;
            y3_next = e3;
            y4_next = e1 + rb;
            y5_next = e0 + ra;
        end
        else
        begin
            y0_next = e0 + e2;
            y1_next = e1 + (e3 >>> 1);
            y2_next = ra;
            y3_next = e0 - (e2 >>> 1);
            y4_next = rb;
            y5_next = e1 - e3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y0_reg <= y0_next;
            y1_reg <= y1_next;
            y2_reg <= y2_next;
            y3_reg <= y3_next;
            y4_reg <= y4_next;
            y5_reg <= y5_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign y0      = y0_reg;
    assign y1      = y1_reg;
    assign y2      = y2_reg;
    assign y3      = y3_reg;
    assign y4      = y4_reg;
    assign y5      = y5_reg;

endmodule

FILE: design/radix6_real_dft_butterfly_top.sv
// Throughput is one transform per cycle, while the output is not stalled, through two
// adder stages, one stage of two constant multipliers, and one rounding and final-sum
// stage, which an input transfer passes in order to reach the output register.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all valid bits and sets the mode register to forward.
module radix6_real_dft_butterfly_top #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic                                      cfg_data,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0 up: x0, x1, x2, x3, x4, x5.
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // Field: batch_last.
    input  logic                                      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // Fields from bit 0 up: y0, y1, y2, y3, y4, y5.
    output logic [((6*(SAMPLE_WIDTH+4)+7)/8)*8-1:0]   m_axis_tdata,
    // Field: batch_done.
    output logic                                      m_axis_tuser
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int F  = COEF_FRAC_BITS;
    localparam int OW = W + 4;

    logic mode_reg;
    logic adv;

    r6dft_pkg::ctl_t in_ctl, ctl2, ctl3, ctl4;

    logic signed [W-1:0]   x0, x1, x2, x3, x4, x5;
    logic signed [W+1:0]   ma, mb;
    logic signed [W+2:0]   u0a, u1a, u2a, u3a;
    logic signed [W+2:0]   u0b, u1b, u2b, u3b;
    logic signed [W+F+3:0] pa, pb;
    logic signed [OW-1:0]  y0, y1, y2, y3, y4, y5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign cfg_ready     = 1'b1;
    assign adv           = !ctl4.valid || m_axis_tready;
    assign s_axis_tready = adv;

    assign x0 = s_axis_tdata[0*W +: W];
    assign x1 = s_axis_tdata[1*W +: W];
    assign x2 = s_axis_tdata[2*W +: W];
    assign x3 = s_axis_tdata[3*W +: W];
    assign x4 = s_axis_tdata[4*W +: W];
    assign x5 = s_axis_tdata[5*W +: W];

    assign in_ctl = '{valid: s_axis_tvalid, last: s_axis_tuser, inv: mode_reg};

    r6dft_pre #(.W(W)) u_pre (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_ctl  (in_ctl),
        .x0      (x0),
        .x1      (x1),
        .x2      (x2),
        .x3      (x3),
        .x4      (x4),
        .x5      (x5),
        .out_ctl (ctl2),
        .ma      (ma),
        .mb      (mb),
        .u0      (u0a),
        .u1      (u1a),
        .u2      (u2a),
        .u3      (u3a)
    );

    r6dft_mul #(.W(W), .F(F)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_ctl  (ctl2),
        .ma      (ma),
        .mb      (mb),
        .u0_in   (u0a),
        .u1_in   (u1a),
        .u2_in   (u2a),
        .u3_in   (u3a),
        .out_ctl (ctl3),
        .pa      (pa),
        .pb      (pb),
        .u0      (u0b),
        .u1      (u1b),
        .u2      (u2b),
        .u3      (u3b)
    );

    r6dft_post #(.W(W), .F(F)) u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_ctl  (ctl3),
        .pa      (pa),
        .pb      (pb),
        .u0      (u0b),
        .u1      (u1b),
        .u2      (u2b),
        .u3      (u3b),
        .out_ctl (ctl4),
        .y0      (y0),
        .y1      (y1),
        .y2      (y2),
        .y3      (y3),
        .y4      (y4),
        .y5      (y5)
    );

    always_comb
    begin
        m_axis_tdata             = '0;
        m_axis_tdata[0*OW +: OW] = y0;
        m_axis_tdata[1*OW +: OW] = y1;
        m_axis_tdata[2*OW +: OW] = y2;
        m_axis_tdata[3*OW +: OW] = y3;
        m_axis_tdata[4*OW +: OW] = y4;
        m_axis_tdata[5*OW +: OW] = y5;
    end

    assign m_axis_tvalid = ctl4.valid;
    assign m_axis_tuser  = ctl4.last;

`ifndef SYNTHESIS
    // A held result must stall the input side.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output is stalled");

    // An accepted transform reaches the output once each later stage advances.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 adv ##1 adv ##1 adv |=> m_axis_tvalid)
        else $error("accepted transform did not reach the output");

    // A bubble in the last internal stage leaves the output empty.
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !ctl3.valid |=> !m_axis_tvalid)
        else $error("result appeared without a transform behind it");
`endif

endmodule
